// ----- rtl/dlr_pkg.sv -----
// Shared types and constants for the DDA line rasterizer.
// Used by every module of the block; depends on nothing.
package dlr_pkg;

    // Default geometry
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 16;

    // Field widths fixed by the register map
    localparam int SCREEN_BITS  = 11;
    localparam int COLOR_BITS   = 8;
    localparam int CFG_DATA_BITS = SCREEN_BITS;
    localparam int REG_IDX_BITS = 3;

    // Register reset values
    localparam logic [SCREEN_BITS-1:0] RST_SCREEN_WIDTH  = 11'd640;
    localparam logic [SCREEN_BITS-1:0] RST_SCREEN_HEIGHT = 11'd480;
    localparam logic [COLOR_BITS-1:0]  RST_LINE_RED      = 8'd0;
    localparam logic [COLOR_BITS-1:0]  RST_LINE_GREEN    = 8'd50;
    localparam logic [COLOR_BITS-1:0]  RST_LINE_BLUE     = 8'd0;

    // Lit green: -50/20 reduces to -5/2; 5*m = (m << 2) + m
    localparam int LIT_SHIFT = 2;
    localparam int LIT_MAX   = 255;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_LINE_RED      = 3'd2,
        REG_LINE_GREEN    = 3'd3,
        REG_LINE_BLUE     = 3'd4
    } dlr_reg_t;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } dlr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_start;
        logic load_step;
        logic div_go;
    } dlr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic steps_zero;
        logic div_done;
    } dlr_stat_t;

endpackage

// ----- rtl/dlr_div.sv -----
// Two-lane restoring divider: |dx|<<FRAC and |dy|<<FRAC by the step count.
// One quotient bit per lane per cycle. Uses dlr_pkg.
module dlr_div
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [COORD_BITS-1:0]        mag_x,
    input  logic [COORD_BITS-1:0]        mag_y,
    input  logic                         neg_x,
    input  logic                         neg_y,
    input  logic [COORD_BITS-1:0]        divisor,
    output logic                         done,
    output logic signed [FRAC_BITS+1:0]  quot_x,
    output logic signed [FRAC_BITS+1:0]  quot_y
);

    localparam int NB    = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(NB);
    localparam int QW    = FRAC_BITS + 2;

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic [COORD_BITS-1:0] rem_reg [2];
    logic [NB-1:0]         num_reg [2];
    logic                  neg_reg [2];
    logic [COORD_BITS-1:0] rem_next [2];
    logic [NB-1:0]         num_next [2];
    logic [COORD_BITS-1:0] mag_in [2];
    logic                  neg_in [2];
    logic signed [QW-1:0]  quot [2];

    assign mag_in[0] = mag_x;
    assign mag_in[1] = mag_y;
    assign neg_in[0] = neg_x;
    assign neg_in[1] = neg_y;

    assign done = busy_reg && (cnt_reg == CNT_W'(NB - 1));

    // One restoring step per lane; quotient bits shift into the numerator
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [COORD_BITS:0] trial;
        logic [COORD_BITS:0] diff;
        logic                fits;

        assign trial = {rem_reg[l], num_reg[l][NB-1]};
        assign fits  = trial >= {1'b0, den_reg};
        assign diff  = trial - {1'b0, den_reg};
        assign rem_next[l] = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        assign num_next[l] = {num_reg[l][NB-2:0], fits};

        // Quotient never exceeds 1.0, so FRAC+1 magnitude bits suffice
        assign quot[l] = neg_reg[l] ? -QW'(num_reg[l][QW-2:0])
                                    :  QW'(num_reg[l][QW-2:0]);

        always_ff @(posedge clk)
        begin
            if (go)
            begin
                rem_reg[l] <= '0;
                num_reg[l] <= {mag_in[l], {FRAC_BITS{1'b0}}};
                neg_reg[l] <= neg_in[l];
            end
            else if (busy_reg)
            begin
                rem_reg[l] <= rem_next[l];
                num_reg[l] <= num_next[l];
            end
        end
    end

    assign quot_x = quot[0];
    assign quot_y = quot[1];

    // Divisor capture
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            den_reg <= divisor;
        end
    end

    // Iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

// ----- rtl/dlr_ctrl.sv -----
// Handshake controller: accepts requests, owns result valid, sequences the divider.
// Uses dlr_pkg for states, commands and status.
module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      kind,
    output logic      out_valid,
    input  logic      out_ready,
    output dlr_cmd_t  cmd,
    input  dlr_stat_t stat
);

    dlr_state_t state_reg;
    dlr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // Outputs and commands
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        accept   = in_valid && in_ready;
        cmd.load_start = accept && (kind == KIND_START);
        cmd.load_step  = accept && (kind == KIND_STEP);
        cmd.div_go     = cmd.load_start && !stat.steps_zero;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.div_go)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result valid: set on accept, cleared when taken
    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/dlr_dpath.sv -----
// Datapath: config registers, line setup, position accumulators, result register.
// Instantiates dlr_div; uses dlr_pkg.
module dlr_dpath
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dlr_cmd_t                        cmd,
    output dlr_stat_t                       stat,
    input  logic                            cfg_we,
    input  logic [REG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0]    start_x,
    input  logic signed [COORD_BITS-1:0]    start_y,
    input  logic signed [COORD_BITS-1:0]    end_x,
    input  logic signed [COORD_BITS-1:0]    end_y,
    input  logic signed [COORD_BITS-1:0]    end_depth,
    output logic signed [COORD_BITS-1:0]    pixel_x,
    output logic signed [COORD_BITS-1:0]    pixel_y,
    output logic                            drawn,
    output logic [COLOR_BITS-1:0]           red,
    output logic [COLOR_BITS-1:0]           green,
    output logic [COLOR_BITS-1:0]           blue,
    output logic                            last
);

    localparam int PW   = COORD_BITS + FRAC_BITS + 1;
    localparam int QW   = FRAC_BITS + 2;
    localparam int CMPW = ((COORD_BITS + 1 > SCREEN_BITS) ? COORD_BITS + 1 : SCREEN_BITS) + 1;
    localparam int LW   = COORD_BITS + LIT_SHIFT + 1;
    localparam logic [PW-1:0] FRAC_ONES = PW'((64'd1 << FRAC_BITS) - 64'd1);

    // Config registers
    logic [SCREEN_BITS-1:0] width_reg;
    logic [SCREEN_BITS-1:0] height_reg;
    logic [COLOR_BITS-1:0]  red_reg;
    logic [COLOR_BITS-1:0]  green_reg;
    logic [COLOR_BITS-1:0]  blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            red_reg    <= RST_LINE_RED;
            green_reg  <= RST_LINE_GREEN;
            blue_reg   <= RST_LINE_BLUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                REG_LINE_RED:      red_reg    <= cfg_data[COLOR_BITS-1:0];
                REG_LINE_GREEN:    green_reg  <= cfg_data[COLOR_BITS-1:0];
                REG_LINE_BLUE:     blue_reg   <= cfg_data[COLOR_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Line setup: deltas, magnitudes, step count
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] ndx;
    logic signed [COORD_BITS:0] ndy;
    logic [COORD_BITS-1:0]      mag_x;
    logic [COORD_BITS-1:0]      mag_y;
    logic [COORD_BITS-1:0]      steps;
    logic                       steps_zero;

    assign dx    = (COORD_BITS + 1)'(end_x) - (COORD_BITS + 1)'(start_x);
    assign dy    = (COORD_BITS + 1)'(end_y) - (COORD_BITS + 1)'(start_y);
    assign ndx   = -dx;
    assign ndy   = -dy;
    assign mag_x = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign mag_y = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign steps = (mag_x > mag_y) ? mag_x : mag_y;

    assign steps_zero = (steps == '0);

    // Per-step increments
    logic signed [QW-1:0] step_x;
    logic signed [QW-1:0] step_y;
    logic                 div_done;

    dlr_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.div_go),
        .mag_x  (mag_x),
        .mag_y  (mag_y),
        .neg_x  (dx[COORD_BITS]),
        .neg_y  (dy[COORD_BITS]),
        .divisor(steps),
        .done   (div_done),
        .quot_x (step_x),
        .quot_y (step_y)
    );

    // Status back to the controller
    assign stat = '{steps_zero: steps_zero, div_done: div_done};

    // Lit green of the first pixel: 2*trunc(5*m/2) for negative depth, clamped
    logic [COORD_BITS-1:0] zmag;
    logic [LW-1:0]         lit_full;
    logic [LW-1:0]         lit_even;
    logic [COLOR_BITS-1:0] lit;

    assign zmag     = $unsigned(-end_depth);
    assign lit_full = (LW'(zmag) << LIT_SHIFT) + LW'(zmag);
    assign lit_even = {lit_full[LW-1:1], 1'b0};

    always_comb
    begin
        priority if (!end_depth[COORD_BITS-1])
        begin
            lit = '0;
        end
        else if (lit_even > LW'(LIT_MAX))
        begin
            lit = COLOR_BITS'(LIT_MAX);
        end
        else
        begin
            lit = lit_even[COLOR_BITS-1:0];
        end
    end

    // Start pixel visibility
    logic start_on;

    assign start_on = !start_x[COORD_BITS-1] && !start_y[COORD_BITS-1]
                   && (CMPW'($unsigned(start_x)) < CMPW'(width_reg))
                   && (CMPW'($unsigned(start_y)) < CMPW'(height_reg));

    // Position advance and truncation toward zero
    logic signed [PW-1:0]  pos_x_reg;
    logic signed [PW-1:0]  pos_y_reg;
    logic signed [PW-1:0]  pos_x_next;
    logic signed [PW-1:0]  pos_y_next;
    logic [PW-1:0]         adj_x;
    logic [PW-1:0]         adj_y;
    logic                  step_on;
    logic [COORD_BITS-1:0] steps_left_reg;
    logic                  active_reg;
    logic                  final_step;

    assign pos_x_next = pos_x_reg + PW'(step_x);
    assign pos_y_next = pos_y_reg + PW'(step_y);
    assign adj_x = pos_x_next + (pos_x_next[PW-1] ? FRAC_ONES : '0);
    assign adj_y = pos_y_next + (pos_y_next[PW-1] ? FRAC_ONES : '0);

    assign step_on = !pos_x_next[PW-1] && !pos_y_next[PW-1]
                  && (CMPW'(pos_x_next[PW-1:FRAC_BITS]) < CMPW'(width_reg))
                  && (CMPW'(pos_y_next[PW-1:FRAC_BITS]) < CMPW'(height_reg));

    assign final_step = (steps_left_reg == COORD_BITS'(1));

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
        end
        else if (cmd.load_start)
        begin
            pos_x_reg      <= PW'(start_x) <<< FRAC_BITS;
            pos_y_reg      <= PW'(start_y) <<< FRAC_BITS;
            steps_left_reg <= steps;
            active_reg     <= !steps_zero;
        end
        else if (cmd.load_step && active_reg)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            steps_left_reg <= steps_left_reg - COORD_BITS'(1);
            if (final_step)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Result register
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic                         drawn_reg;
    logic [COLOR_BITS-1:0]        red_out_reg;
    logic [COLOR_BITS-1:0]        green_out_reg;
    logic [COLOR_BITS-1:0]        blue_out_reg;
    logic                         last_reg;

    always_ff @(posedge clk)
    begin
        priority if (cmd.load_start)
        begin
            pixel_x_reg   <= start_x;
            pixel_y_reg   <= start_y;
            drawn_reg     <= start_on;
            red_out_reg   <= red_reg;
            green_out_reg <= lit;
            blue_out_reg  <= blue_reg;
            last_reg      <= steps_zero;
        end
        else if (cmd.load_step && active_reg)
        begin
            pixel_x_reg   <= adj_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            pixel_y_reg   <= adj_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            drawn_reg     <= step_on;
            red_out_reg   <= red_reg;
            green_out_reg <= green_reg;
            blue_out_reg  <= blue_reg;
            last_reg      <= final_step;
        end
        else if (cmd.load_step)
        begin
            // step with no line in progress
            pixel_x_reg   <= '0;
            pixel_y_reg   <= '0;
            drawn_reg     <= 1'b0;
            red_out_reg   <= '0;
            green_out_reg <= '0;
            blue_out_reg  <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign drawn   = drawn_reg;
    assign red     = red_out_reg;
    assign green   = green_out_reg;
    assign blue    = blue_out_reg;
    assign last    = last_reg;

endmodule

// ----- rtl/dda_line_rasterizer.sv -----
// Top level of the DDA line rasterizer: controller plus datapath.
// Depends on dlr_pkg, dlr_ctrl, dlr_dpath (and dlr_div below it).
//
//   channel  handshake                  payload
//   cfg      cfg_we                     cfg_index, cfg_data
//   in       in_valid / in_ready        kind, start_x, start_y, end_x, end_y, end_depth
//   out      out_valid / out_ready      pixel_x, pixel_y, drawn, red, green, blue, last
//
// A step request and a zero-length start do not wait on the divider; steps run back to back
// while each result is taken. A start with a nonzero step count then holds in_ready low while
// the shared two-lane serial divider forms the increments. The result register frees the
// input side: a new request is taken in the cycle its predecessor's result is taken. No
// clearing pass after reset; the control, config and line state registers reset at once.
module dda_line_rasterizer
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [REG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic signed [COORD_BITS-1:0]  end_depth,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          drawn,
    output logic [COLOR_BITS-1:0]         red,
    output logic [COLOR_BITS-1:0]         green,
    output logic [COLOR_BITS-1:0]         blue,
    output logic                          last
);

    dlr_cmd_t  cmd;
    dlr_stat_t stat;

    dlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dlr_dpath #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .end_depth(end_depth),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .drawn    (drawn),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .last     (last)
    );

endmodule

// ----- rtl/dlr_checker.sv -----
// Port-level checks for dda_line_rasterizer, attached by bind.
// Depends on dlr_pkg.
module dlr_checker
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          kind,
    input logic signed [COORD_BITS-1:0]  start_x,
    input logic signed [COORD_BITS-1:0]  start_y,
    input logic signed [COORD_BITS-1:0]  end_x,
    input logic signed [COORD_BITS-1:0]  end_y,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_BITS-1:0]  pixel_x,
    input logic                          last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(last))
        else $error("stalled result changed");

    // No request taken while an untaken result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && out_valid && !out_ready))
        else $error("request accepted over a pending result");

    // Every accepted request shows a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request produced no result");

    // A zero-length line ends on its start pixel
    a_zero_len_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_START)
            && (start_x == end_x) && (start_y == end_y) |=> out_valid && last)
        else $error("zero-length line not marked last");

endmodule

bind dda_line_rasterizer dlr_checker #(.COORD_BITS(COORD_BITS)) u_dlr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_x  (pixel_x),
    .last     (last)
);

// ----- verif/tb_dda_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dda_line_rasterizer: line start and step requests against an
// in-bench DDA predictor, each pixel compared field by field. Needs dlr_pkg and the RTL.
module tb_dda_line_rasterizer;
    import dlr_pkg::*;

    localparam int COORD_BITS = DEF_COORD_BITS;
    localparam int FRAC_BITS = DEF_FRAC_BITS;
    localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
    // settle time after the bench goes idle: covers a full divider run, with slack
    localparam int SETTLE_CYCLES = 2 * (COORD_BITS + FRAC_BITS) + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        logic   kind;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t depth;
    } line_req_t;

    typedef struct {
        coord_t                x;
        coord_t                y;
        logic                  drawn;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  last;
    } pixel_t;

    // clock, reset, ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [REG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind;
    coord_t start_x, start_y, end_x, end_y, end_depth;
    logic out_valid;
    logic out_ready = 1'b0;
    coord_t pixel_x, pixel_y;
    logic drawn;
    logic [COLOR_BITS-1:0] red, green, blue;
    logic last;

    line_req_t cur_req = '{kind: KIND_START, default: '0};

    assign kind      = cur_req.kind;
    assign start_x   = cur_req.sx;
    assign start_y   = cur_req.sy;
    assign end_x     = cur_req.ex;
    assign end_y     = cur_req.ey;
    assign end_depth = cur_req.depth;

    dda_line_rasterizer u_dut (.*);

    // bench state
    line_req_t queued_requests[$];
    pixel_t    pending_pixels[$];
    int        err_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_ticket = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        cycle_count = 0;

    // predictor copy of registers and line state
    logic [SCREEN_BITS-1:0] scr_w = RST_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0] scr_h = RST_SCREEN_HEIGHT;
    logic [COLOR_BITS-1:0]  col_r = RST_LINE_RED;
    logic [COLOR_BITS-1:0]  col_g = RST_LINE_GREEN;
    logic [COLOR_BITS-1:0]  col_b = RST_LINE_BLUE;
    longint pos_x = 0, pos_y = 0, inc_x = 0, inc_y = 0;
    longint steps_rem = 0;
    bit     line_live = 1'b0;

    // on screen is judged on the fixed-point position: any negative fraction is off
    function automatic logic on_screen(input longint px, input longint py);
        if (px < 0 || py < 0)
            return 1'b0;
        return (px / FIX_ONE < longint'(scr_w)) && (py / FIX_ONE < longint'(scr_h));
    endfunction

    // next pixel of the DDA engine for one request; advances the line state
    function automatic pixel_t dda_next_pixel(input line_req_t r);
        pixel_t p;
        longint dx, dy, adx, ady, span, lit;
        p = '{default: '0};
        if (r.kind == KIND_START) begin
            dx = longint'(r.ex) - longint'(r.sx);
            dy = longint'(r.ey) - longint'(r.sy);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            span = adx > ady ? adx : ady;
            // lit green from depth, -50/20 as -5/2 truncated toward zero
            lit = ((-5 * longint'(r.depth)) / 2) * 2;
            if (lit < 0)
                lit = 0;
            if (lit > LIT_MAX)
                lit = LIT_MAX;
            pos_x = longint'(r.sx) * FIX_ONE;
            pos_y = longint'(r.sy) * FIX_ONE;
            inc_x = span > 0 ? (dx * FIX_ONE) / span : 0;
            inc_y = span > 0 ? (dy * FIX_ONE) / span : 0;
            steps_rem = span;
            line_live = span > 0;
            p.x = r.sx;
            p.y = r.sy;
            p.drawn = on_screen(pos_x, pos_y);
            p.red = col_r;
            p.green = lit[COLOR_BITS-1:0];
            p.blue = col_b;
            p.last = (span == 0);
        end else if (!line_live || steps_rem == 0) begin
            // step with no line: blank pixel flagged last
            line_live = 1'b0;
            p.last = 1'b1;
        end else begin
            pos_x += inc_x;
            pos_y += inc_y;
            steps_rem--;
            if (steps_rem == 0)
                line_live = 1'b0;
            p.x = coord_t'(pos_x / FIX_ONE);
            p.y = coord_t'(pos_y / FIX_ONE);
            p.drawn = on_screen(pos_x, pos_y);
            p.red = col_r;
            p.green = col_g;
            p.blue = col_b;
            p.last = (steps_rem == 0);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] got,
                               input logic [COORD_BITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // request driver: predict on acceptance, then offer the next queued request
    always @(posedge clk or negedge rst_n) begin : drive_proc
        line_req_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                pending_pixels.insert(pending_pixels.size(), dda_next_pixel(cur_req));
            if (!in_valid || in_ready) begin
                if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_requests.pop_front();
                    cur_req <= nxt;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // pixel sink ready: random stalls, or a long hold when one is asked for
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_ticket) begin
            hold_seen <= hold_ticket;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // pixel monitor
    always @(posedge clk) begin : check_proc
        pixel_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with no request outstanding");
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", pixel_x, want.x);
                check_field("pixel_y", pixel_y, want.y);
                check_field("drawn", COORD_BITS'(drawn), COORD_BITS'(want.drawn));
                check_field("red", COORD_BITS'(red), COORD_BITS'(want.red));
                check_field("green", COORD_BITS'(green), COORD_BITS'(want.green));
                check_field("blue", COORD_BITS'(blue), COORD_BITS'(want.blue));
                check_field("last", COORD_BITS'(last), COORD_BITS'(want.last));
            end
        end
    end

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = val;
            REG_SCREEN_HEIGHT: scr_h = val;
            REG_LINE_RED:      col_r = val[COLOR_BITS-1:0];
            REG_LINE_GREEN:    col_g = val[COLOR_BITS-1:0];
            REG_LINE_BLUE:     col_b = val[COLOR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int w, input int h, input int r, input int g, input int b);
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_SCREEN_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(REG_LINE_RED, CFG_DATA_BITS'(r));
        write_reg(REG_LINE_GREEN, CFG_DATA_BITS'(g));
        write_reg(REG_LINE_BLUE, CFG_DATA_BITS'(b));
    endtask

    // wait until every request is taken and every pixel checked, then let the divider settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (queued_requests.size() != 0 || in_valid || pending_pixels.size() != 0 ||
               hold_left != 0 || hold_seen != hold_ticket);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    task automatic push_start(input int sx, input int sy, input int ex, input int ey,
                              input int depth);
        line_req_t r;
        r.kind = KIND_START;
        r.sx = coord_t'(sx);
        r.sy = coord_t'(sy);
        r.ex = coord_t'(ex);
        r.ey = coord_t'(ey);
        r.depth = coord_t'(depth);
        queued_requests.insert(queued_requests.size(), r);
    endtask

    // step requests carry random junk in the ignored fields
    task automatic push_steps(input int n);
        line_req_t r;
        repeat (n) begin
            r.kind = KIND_STEP;
            r.sx = coord_t'($urandom);
            r.sy = coord_t'($urandom);
            r.ex = coord_t'($urandom);
            r.ey = coord_t'($urandom);
            r.depth = coord_t'($urandom);
            queued_requests.insert(queued_requests.size(), r);
        end
    endtask

    // mostly whole lines with random content; some cut short, some stray steps
    task automatic queue_lines(input int n_items, input bit near_origin);
        int pushed, roll, reach, sx, sy, ex, ey, depth, adx, ady, span, n_steps;
        pushed = 0;
        while (pushed < n_items) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                push_steps(1);
                pushed++;
                continue;
            end
            reach = roll < 15 ? 4095 : (roll < 35 ? 60 : 12);
            if (near_origin) begin
                sx = int'($urandom_range(6)) - 3;
                sy = int'($urandom_range(6)) - 3;
            end else if (roll % 2 == 0) begin
                sx = int'($urandom_range(740)) - 40;
                sy = int'($urandom_range(560)) - 40;
            end else begin
                sx = clamp_coord(int'($urandom_range(4095)) + COORD_MIN);
                sy = clamp_coord(int'($urandom_range(4095)) + COORD_MIN);
            end
            ex = clamp_coord(sx + int'($urandom_range(2 * reach)) - reach);
            ey = clamp_coord(sy + int'($urandom_range(2 * reach)) - reach);
            depth = ($urandom_range(1) == 0) ? int'($urandom_range(70)) - 60
                                             : int'($urandom_range(4095)) + COORD_MIN;
            adx = ex > sx ? ex - sx : sx - ex;
            ady = ey > sy ? ey - sy : sy - ey;
            span = adx > ady ? adx : ady;
            if (span > 60)
                n_steps = $urandom_range(40);
            else if (roll % 7 == 0)
                n_steps = $urandom_range(span);
            else
                n_steps = span + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
            push_start(sx, sy, ex, ey, depth);
            push_steps(n_steps);
            pushed += 1 + n_steps;
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 17;
        recv_idle_pct = 59;

        // directed, reset register values
        push_steps(1);                                        // step with no line
        push_start(0, 0, 0, 0, 0);                            // zero length
        push_steps(1);
        push_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        push_steps(2);
        push_start(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        push_steps(1);
        push_start(639, 479, 639, 479, -52);                  // last visible pixel, green clamps
        push_start(0, 3, -2, 8, -1);                          // x goes to negative fraction
        push_steps(6);                                        // full line plus one idle step
        push_start(10, 10, 7, 17, -51);
        push_steps(7);
        wait_idle();

        // large screen, full colors, unmapped index ignored
        write_all(2047, 2047, 255, 255, 255);
        write_reg(REG_UNMAPPED, 11'h5A5);
        queue_lines(100, 1'b0);
        wait_idle();

        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        push_start(5, 5, 400, 200, -30);
        push_steps(150);
        hold_ticket++;
        wait_idle();

        // swapped idling; tiny screen, black lines
        send_idle_pct = 59;
        recv_idle_pct = 17;
        write_all(1, 1, 0, 0, 0);
        queue_lines(50, 1'b1);
        wait_idle();
        // random colors written with the upper data bits set
        write_all($urandom_range(1, 2047), $urandom_range(1, 2047),
                  $urandom_range(2047) | 11'h700, $urandom_range(2047) | 11'h700,
                  $urandom_range(2047) | 11'h700);
        queue_lines(100, 1'b0);
        wait_idle();

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(640, 480, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        queue_lines(60, 1'b0);
        wait_idle();

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
